// ===== design/gmtp_pkg.sv =====
// Shared types and constants for the grid map text parser.
// No dependencies; the parser, result queue, top-level and test files import this package.
package gmtp_pkg;

    localparam int DEF_MAX_COLS     = 256;
    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_OWNER_DIGITS = 2;

    localparam int CHAR_W  = 8;
    localparam int PID_W   = 7;
    localparam int COORD_W = 9;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_OBJECT   = 2'd0,
        KIND_SIZE     = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CHAR_W-1:0] map_char;
        logic              end_of_map;
    } t_in_item;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  object_char;
        logic [PID_W-1:0]   player_id;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] expected_columns;
        logic               last_of_run;
    } t_out_item;

    // Results produced by one byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    function automatic t_push push_add(t_push p, t_out_item x);
        t_push q;
        q = p;
        if (p.count == 2'd0) begin
            q.item0 = x;
        end else begin
            q.item1 = x;
        end
        q.count = p.count + 2'd1;
        return q;
    endfunction

endpackage

// ===== design/gmtp_stream_if.sv =====
// Valid/ready stream interface used for the byte input and result output.
// The payload type is set at instantiation (gmtp_pkg structs).
interface gmtp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/gmtp_parse.sv =====
// Parser state and combinational step logic: one accepted byte in, up to two results out.
// Depends on gmtp_pkg.
module gmtp_parse #(
    parameter int MAX_COLS     = gmtp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = gmtp_pkg::DEF_MAX_ROWS,
    parameter int OWNER_DIGITS = gmtp_pkg::DEF_OWNER_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  gmtp_pkg::t_in_item i_item,
    output gmtp_pkg::t_push    o_push
);
    import gmtp_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 2);
    localparam int RW = $clog2(MAX_ROWS + 2);
    localparam int OW = $clog2(10 ** OWNER_DIGITS);
    localparam int DW = $clog2(OWNER_DIGITS + 1);
    localparam logic [CW-1:0] ColMax = CW'(MAX_COLS);
    localparam logic [RW-1:0] RowMax = RW'(MAX_ROWS);
    localparam logic [DW-1:0] DigMax = DW'(OWNER_DIGITS);

    logic              r_reading_owner, n_reading_owner;
    logic [CHAR_W-1:0] r_held_char, n_held_char;
    logic [DW-1:0]     r_owner_digits, n_owner_digits;
    logic [OW-1:0]     r_owner_value, n_owner_value;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_first, n_first;
    logic              r_last_nl, n_last_nl;
    logic              r_halted, n_halted;

    logic [CHAR_W-1:0] w_char;
    logic              w_place_ovf;
    logic [CW-1:0]     w_col_inc;
    logic [CW-1:0]     w_col_end;
    logic [CW-1:0]     w_col_dot;
    logic [RW-1:0]     w_row_inc;
    logic [RW-1:0]     w_height;
    logic [OW-1:0]     w_owner_acc;
    t_out_item         w_place_res;
    t_push             w_push;

    function automatic t_out_item mk(t_kind k, logic [CHAR_W-1:0] ch, logic [OW-1:0] pid,
                                     logic [CW-1:0] col, logic [RW-1:0] row,
                                     logic [CW-1:0] expc);
        t_out_item r;
        r.kind             = k;
        r.object_char      = ch;
        r.player_id        = PID_W'(pid);
        r.column           = COORD_W'(col);
        r.row              = COORD_W'(row);
        r.expected_columns = COORD_W'(expc);
        r.last_of_run      = 1'b0;
        return r;
    endfunction

    assign w_char      = i_item.map_char;
    assign w_place_ovf = (r_col >= ColMax) || (r_row >= RowMax);
    assign w_col_inc   = r_col + CW'(1);
    // column after a pending object is closed
    assign w_col_end   = r_reading_owner ? w_col_inc : r_col;
    assign w_col_dot   = w_col_end + CW'(1);
    assign w_row_inc   = r_row + RW'(1);
    assign w_height    = r_row + RW'(!r_last_nl);
    assign w_owner_acc = OW'(r_owner_value * OW'(10)) + OW'(w_char - CH_ZERO);
    assign w_place_res = w_place_ovf
        ? mk(KIND_OVERFLOW, '0, '0, r_col, r_row, '0)
        : mk(KIND_OBJECT, r_held_char, r_owner_value, r_col, r_row, '0);

    always_comb begin
        n_reading_owner = r_reading_owner;
        n_held_char     = r_held_char;
        n_owner_digits  = r_owner_digits;
        n_owner_value   = r_owner_value;
        n_col           = r_col;
        n_row           = r_row;
        n_first         = r_first;
        n_last_nl       = r_last_nl;
        n_halted        = r_halted;
        w_push          = '0;

        if (i_take && i_item.end_of_map) begin
            if (!r_halted) begin
                if (r_reading_owner) begin
                    w_push = push_add(w_push, w_place_res);
                end
                if (!(r_reading_owner && w_place_ovf)) begin
                    if (w_height > RowMax) begin
                        w_push = push_add(w_push,
                            mk(KIND_OVERFLOW, '0, '0, r_first, w_height, '0));
                    end else begin
                        w_push = push_add(w_push,
                            mk(KIND_SIZE, '0, '0, r_first, w_height, '0));
                    end
                end
            end
            n_reading_owner = 1'b0;
            n_held_char     = '0;
            n_owner_digits  = '0;
            n_owner_value   = '0;
            n_col           = '0;
            n_row           = '0;
            n_first         = '0;
            n_last_nl       = 1'b1;
            n_halted        = 1'b0;
        end else if (i_take && !r_halted) begin
            case (w_char)
                CH_NUL: begin
                    n_halted = 1'b1;
                end
                CH_NL: begin
                    if (r_reading_owner) begin
                        n_reading_owner = 1'b0;
                        w_push = push_add(w_push, w_place_res);
                    end
                    if (r_reading_owner && w_place_ovf) begin
                        n_halted = 1'b1;
                    end else if (r_row != '0 && r_first != w_col_end) begin
                        w_push = push_add(w_push,
                            mk(KIND_MISMATCH, '0, '0, w_col_end, r_row, r_first));
                        n_halted = 1'b1;
                    end else if (w_row_inc > RowMax) begin
                        w_push = push_add(w_push,
                            mk(KIND_OVERFLOW, '0, '0, w_col_end, w_row_inc, '0));
                        n_halted = 1'b1;
                    end else begin
                        if (r_row == '0) begin
                            n_first = w_col_end;
                        end
                        n_row     = w_row_inc;
                        n_col     = '0;
                        n_last_nl = 1'b1;
                    end
                end
                CH_SPACE, CH_TAB: begin
                    if (r_reading_owner) begin
                        n_reading_owner = 1'b0;
                        w_push = push_add(w_push, w_place_res);
                        if (w_place_ovf) begin
                            n_halted = 1'b1;
                        end else begin
                            n_col = w_col_inc;
                        end
                    end
                end
                CH_DOT: begin
                    if (r_reading_owner) begin
                        n_reading_owner = 1'b0;
                        w_push = push_add(w_push, w_place_res);
                    end
                    if (r_reading_owner && w_place_ovf) begin
                        n_halted = 1'b1;
                    end else if (w_col_dot > ColMax) begin
                        w_push = push_add(w_push,
                            mk(KIND_OVERFLOW, '0, '0, w_col_dot, r_row, '0));
                        n_halted = 1'b1;
                    end else begin
                        n_col     = w_col_dot;
                        n_last_nl = 1'b0;
                    end
                end
                default: begin
                    if (r_reading_owner && (w_char inside {[CH_ZERO:CH_NINE]})) begin
                        if (r_owner_digits < DigMax) begin
                            n_owner_value  = w_owner_acc;
                            n_owner_digits = r_owner_digits + DW'(1);
                        end
                        n_last_nl = 1'b0;
                    end else if (r_reading_owner && w_place_ovf) begin
                        w_push          = push_add(w_push, w_place_res);
                        n_reading_owner = 1'b0;
                        n_halted        = 1'b1;
                    end else begin
                        if (r_reading_owner) begin
                            w_push = push_add(w_push, w_place_res);
                            n_col  = w_col_inc;
                        end
                        n_held_char     = w_char;
                        n_reading_owner = 1'b1;
                        n_owner_digits  = '0;
                        n_owner_value   = '0;
                        n_last_nl       = 1'b0;
                    end
                end
            endcase
        end

        w_push.item0.last_of_run = (w_push.count == 2'd1);
        w_push.item1.last_of_run = (w_push.count == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading_owner <= 1'b0;
            r_held_char     <= '0;
            r_owner_digits  <= '0;
            r_owner_value   <= '0;
            r_col           <= '0;
            r_row           <= '0;
            r_first         <= '0;
            r_last_nl       <= 1'b1;
            r_halted        <= 1'b0;
        end else begin
            r_reading_owner <= n_reading_owner;
            r_held_char     <= n_held_char;
            r_owner_digits  <= n_owner_digits;
            r_owner_value   <= n_owner_value;
            r_col           <= n_col;
            r_row           <= n_row;
            r_first         <= n_first;
            r_last_nl       <= n_last_nl;
            r_halted        <= n_halted;
        end
    end

    assign o_push = w_push;

endmodule

// ===== design/gmtp_res_fifo.sv =====
// Result queue: takes up to two results per cycle, delivers one per transaction.
// Depends on gmtp_pkg.
module gmtp_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gmtp_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output gmtp_pkg::t_out_item o_item,
    output logic                o_room
);
    import gmtp_pkg::*;

    t_out_item              r_slot [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_head;
    logic [RES_CNT_W-1:0]   r_count;
    logic [RES_PTR_W-1:0]   w_tail0;
    logic [RES_PTR_W-1:0]   w_tail1;

    assign w_tail0 = r_head + r_count[RES_PTR_W-1:0];
    assign w_tail1 = w_tail0 + RES_PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_head];
    assign o_room  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_pop) begin
                r_head <= r_head + RES_PTR_W'(1);
            end
            r_count <= r_count + RES_CNT_W'(i_push.count) - RES_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slot[w_tail0] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_slot[w_tail1] <= i_push.item1;
        end
    end

endmodule

// ===== design/grid_map_text_parser_top.sv =====
// Grid map text parser, top level: byte stream in, object/size/error results out.
// Depends on gmtp_pkg, gmtp_stream_if, gmtp_parse and gmtp_res_fifo.
//
// Takes one map byte per cycle while the result queue has room. Each byte is parsed in
// the cycle it is accepted and yields zero, one or two results, which enter a four-entry
// result queue; the input is ready whenever the queue has two free entries. The output
// port delivers one result per transaction, so a byte giving two results (end marker
// closing a pending object, or a newline or dot closing an object and then failing the
// row check or a size limit) gives two output transactions.
// There is no clearing pass after reset.
module grid_map_text_parser_top #(
    parameter int MAX_COLS     = gmtp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = gmtp_pkg::DEF_MAX_ROWS,
    parameter int OWNER_DIGITS = gmtp_pkg::DEF_OWNER_DIGITS
) (
    input logic           i_clk,
    input logic           i_rst_n,
    gmtp_stream_if.sink   i_in,
    gmtp_stream_if.source o_out
);
    import gmtp_pkg::*;

    t_in_item  w_item;
    t_push     w_push;
    t_out_item w_res;
    logic      w_room;
    logic      w_take;
    logic      w_res_valid;

    assign w_item      = i_in.data;
    assign i_in.ready  = w_room;
    assign w_take      = i_in.valid && w_room;
    assign o_out.valid = w_res_valid;
    assign o_out.data  = w_res;

    gmtp_parse #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .OWNER_DIGITS(OWNER_DIGITS)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_item (w_item),
        .o_push (w_push)
    );

    gmtp_res_fifo u_res_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (w_res_valid && o_out.ready),
        .o_valid(w_res_valid),
        .o_item (w_res),
        .o_room (w_room)
    );

endmodule

// ===== test/gmtp_checker.sv =====
`timescale 1ns / 100ps
// Checker for the grid map text parser: watches both streams, predicts results.
// Depends on gmtp_pkg; instantiated by grid_map_text_parser_top_tb.
module gmtp_checker #(
    parameter int MAX_COLS     = gmtp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = gmtp_pkg::DEF_MAX_ROWS,
    parameter int OWNER_DIGITS = gmtp_pkg::DEF_OWNER_DIGITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  gmtp_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  gmtp_pkg::t_out_item i_out_data,
    output int                  o_errors,
    output int                  o_outstanding
);
    import gmtp_pkg::*;

    // Parser state mirror
    logic              owner_mode;
    logic [CHAR_W-1:0] obj_char;
    int unsigned       pid_digits;
    int unsigned       pid_val;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    int unsigned       width0;
    logic              nl_last;
    logic              stopped;

    t_out_item step_results[$];
    t_out_item expected_results[$];

    function automatic void restart_parser();
        owner_mode = 1'b0;
        obj_char   = '0;
        pid_digits = 0;
        pid_val    = 0;
        col_cnt    = 0;
        row_cnt    = 0;
        width0     = 0;
        nl_last    = 1'b1;
        stopped    = 1'b0;
    endfunction

    function automatic void add_result(t_kind k, logic [CHAR_W-1:0] ch, int unsigned pid,
                                       int unsigned c, int unsigned r, int unsigned e);
        t_out_item x;
        x.kind             = k;
        x.object_char      = ch;
        x.player_id        = pid[PID_W-1:0];
        x.column           = c[COORD_W-1:0];
        x.row              = r[COORD_W-1:0];
        x.expected_columns = e[COORD_W-1:0];
        x.last_of_run      = 1'b0;
        step_results.push_back(x);
    endfunction

    function automatic void report_overflow(int unsigned c, int unsigned r);
        add_result(KIND_OVERFLOW, '0, 0, c, r, 0);
        stopped = 1'b1;
    endfunction

    function automatic void place_object();
        owner_mode = 1'b0;
        if (col_cnt >= MAX_COLS || row_cnt >= MAX_ROWS) begin
            report_overflow(col_cnt, row_cnt);
        end else begin
            add_result(KIND_OBJECT, obj_char, pid_val, col_cnt, row_cnt, 0);
        end
    endfunction

    function automatic void start_object(logic [CHAR_W-1:0] c);
        obj_char   = c;
        owner_mode = 1'b1;
        pid_digits = 0;
        pid_val    = 0;
    endfunction

    function automatic void parse_byte(t_in_item it);
        int unsigned h;
        logic        is_digit;
        step_results.delete();
        is_digit = (it.map_char >= CH_ZERO) && (it.map_char <= CH_NINE);
        if (it.end_of_map) begin
            if (!stopped) begin
                if (owner_mode) place_object();
                if (!stopped) begin
                    h = row_cnt + (nl_last ? 0 : 1);
                    if (h > MAX_ROWS) begin
                        report_overflow(width0, h);
                    end else begin
                        add_result(KIND_SIZE, '0, 0, width0, h, 0);
                    end
                end
            end
            restart_parser();
        end else if (!stopped) begin
            case (it.map_char)
                CH_NUL: begin
                    stopped = 1'b1;
                end
                CH_NL: begin
                    if (owner_mode) begin
                        place_object();
                        if (!stopped) col_cnt++;
                    end
                    if (!stopped) begin
                        if (row_cnt == 0) begin
                            width0 = col_cnt;
                        end else if (width0 != col_cnt) begin
                            add_result(KIND_MISMATCH, '0, 0, col_cnt, row_cnt, width0);
                            stopped = 1'b1;
                        end
                    end
                    if (!stopped) begin
                        if (row_cnt + 1 > MAX_ROWS) begin
                            report_overflow(col_cnt, row_cnt + 1);
                        end else begin
                            row_cnt++;
                            col_cnt = 0;
                            nl_last = 1'b1;
                        end
                    end
                end
                CH_SPACE, CH_TAB: begin
                    if (owner_mode) begin
                        place_object();
                        if (!stopped) col_cnt++;
                    end
                end
                CH_DOT: begin
                    if (owner_mode) begin
                        place_object();
                        if (!stopped) col_cnt++;
                    end
                    if (!stopped) begin
                        col_cnt++;
                        if (col_cnt > MAX_COLS) begin
                            report_overflow(col_cnt, row_cnt);
                        end else begin
                            nl_last = 1'b0;
                        end
                    end
                end
                default: begin
                    if (owner_mode && is_digit) begin
                        if (pid_digits < OWNER_DIGITS) begin
                            pid_val = pid_val * 10 + (it.map_char - CH_ZERO);
                            pid_digits++;
                        end
                        nl_last = 1'b0;
                    end else if (owner_mode) begin
                        place_object();
                        if (!stopped) begin
                            col_cnt++;
                            start_object(it.map_char);
                            nl_last = 1'b0;
                        end
                    end else begin
                        start_object(it.map_char);
                        nl_last = 1'b0;
                    end
                end
            endcase
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size()-1].last_of_run = 1'b1;
        end
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            restart_parser();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: kind %0d column %0d row %0d",
                           i_out_data.kind, i_out_data.column, i_out_data.row);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_out_data.kind);
                    check_field("object_char", want.object_char, i_out_data.object_char);
                    check_field("player_id", want.player_id, i_out_data.player_id);
                    check_field("column", want.column, i_out_data.column);
                    check_field("row", want.row, i_out_data.row);
                    check_field("expected_columns", want.expected_columns,
                                i_out_data.expected_columns);
                    check_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

// ===== test/grid_map_text_parser_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for grid_map_text_parser_top: drives map bytes, stalls the output.
// Depends on gmtp_pkg, gmtp_stream_if, the design and gmtp_checker.
module grid_map_text_parser_top_tb;
    import gmtp_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   burst_left;
    int   items_sent;

    gmtp_stream_if #(.T(t_in_item))  in_ch ();
    gmtp_stream_if #(.T(t_out_item)) out_ch ();

    grid_map_text_parser_top dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    gmtp_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("** grid_map_text_parser_top: FAILED **");
        $finish;
    end

    // Output stall pattern, switching at random between four ready modes
    initial begin
        int mode;
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 96)) begin
                @(negedge clk);
                phase++;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (phase % 5 != 0);
                endcase
            end
        end
    end

    task automatic send(input logic [CHAR_W-1:0] ch, input logic eom);
        t_in_item it;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        it.map_char   = ch;
        it.end_of_map = eom;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send(ch, 1'b0);
    endtask

    task automatic send_end();
        send(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_blank();
        send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    function automatic logic [CHAR_W-1:0] random_obj_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(1, 255));
        end while (c == CH_TAB || c == CH_NL || c == CH_SPACE || c == CH_DOT);
        return c;
    endfunction

    // Mostly well-formed rectangular maps, with the odd wrong row width or stray byte
    task automatic send_random_map();
        int                w;
        int                h;
        int                cells;
        logic              open_obj;
        logic [CHAR_W-1:0] ch;
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        for (int r = 0; r < h; r++) begin
            cells = w;
            if ($urandom_range(0, 11) == 0) cells = w + $urandom_range(0, 2) - 1;
            open_obj = 1'b0;
            if ($urandom_range(0, 7) == 0) send_blank();
            for (int c = 0; c < cells; c++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_char(CH_DOT);
                    open_obj = 1'b0;
                end else begin
                    ch = random_obj_char();
                    if (open_obj && ch >= CH_ZERO && ch <= CH_NINE) send_blank();
                    send_char(ch);
                    repeat ($urandom_range(0, 3))
                        send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                    open_obj = 1'b1;
                    if ($urandom_range(0, 1)) begin
                        send_blank();
                        open_obj = 1'b0;
                        if ($urandom_range(0, 3) == 0) send_blank();
                    end
                end
            end
            if (r < h - 1 || $urandom_range(0, 1)) send_char(CH_NL);
            if ($urandom_range(0, 15) == 0) send_char(CHAR_W'($urandom_range(0, 255)));
        end
        send_end();
    endtask

    task automatic send_noise_map();
        repeat ($urandom_range(1, 12)) send_char(CHAR_W'($urandom_range(0, 255)));
        send_end();
    endtask

    initial begin
        int start_items;
        int next_drain;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        rst_n       = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // extra owner digit, digit starting an object, last row with no newline
        send_text("A123 .\nB\t7\nZ");
        send_end();
        // object closed by a newline that also fails the row width check
        send_text("..\nC\nX");
        send_end();
        // zero byte halts quietly
        send_text("Q");
        send_char(CH_NUL);
        send_text("R");
        send_end();
        send_char(8'hFF);
        send_end();
        send_text(" \t");
        send_end();
        drain();

        // size extremes
        repeat (256) send_char(CH_DOT);
        send_text("W");
        send_end();
        repeat (257) send_char(CH_DOT);
        send_end();
        repeat (257) send_char(CH_NL);
        send_end();
        drain();

        start_items = items_sent;
        next_drain  = 150;
        while (items_sent - start_items < 350) begin
            if ($urandom_range(0, 7) == 0) begin
                send_noise_map();
            end else begin
                send_random_map();
            end
            if (items_sent - start_items >= next_drain) begin
                drain();
                next_drain += 150;
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (errors == 0) begin
            $display("** grid_map_text_parser_top: PASSED **");
        end else begin
            $display("** grid_map_text_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
